// ===== hdl/hkoi_pkg.sv =====
// package for the hashed key offset index
// holds field widths, mode and state codes, and the controller/datapath structs
// no dependencies

package hkoi_pkg;

   localparam int MODE_W      = 2;
   localparam int HASH_W      = 32;
   localparam int OFF_W       = 16;
   localparam int ENTRY_W     = HASH_W + OFF_W;
   localparam int DEF_BUCKETS = 16;
   localparam int DEF_WAYS    = 4;

   // bucket remainder is built 8 hash bits per cycle, msb first
   localparam int DIV_BITS  = 8;
   localparam int DIV_STEPS = HASH_W / DIV_BITS;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic [MODE_W-1:0] {
      MODE_UPDATE = 2'd0,
      MODE_FIND   = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic load;      // capture request fields, seed remainder unit
      logic rd_req;    // read bucket row using the masked request hash
      logic div_step;  // advance remainder unit by one digit
      logic rd_rem;    // read bucket row using the finished remainder
      logic exec;      // compare, write back, load result register
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic div_last;
      logic out_busy;
   } sts_type;

endpackage

// ===== hdl/hkoi_req_if.sv =====
// request channel interface: valid/ready handshake with mode, hash and offset
// depends on hkoi_pkg

interface hkoi_req_if import hkoi_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [HASH_W-1:0] key_digest;
   logic [OFF_W-1:0]  offset;

   modport source (output valid, output mode, output key_digest, output offset, input ready);
   modport sink   (input valid, input mode, input key_digest, input offset, output ready);
endinterface

// ===== hdl/hkoi_rsp_if.sv =====
// response channel interface: valid/ready handshake with found, offset and status
// depends on hkoi_pkg

interface hkoi_rsp_if import hkoi_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             found;
   logic [OFF_W-1:0] offset_out;
   logic             status;

   modport source (output valid, output found, output offset_out, output status, input ready);
   modport sink   (input valid, input found, input offset_out, input status, output ready);
endinterface

// ===== hdl/hkoi_ctrl.sv =====
// controller state machine for the hashed key offset index
// depends on hkoi_pkg; drives the datapath through cmd_type

module hkoi_ctrl import hkoi_pkg::*; #(
   parameter int BUCKETS = DEF_BUCKETS
) (
   input  logic    clock,
   input  logic    reset,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    req_ready
);

   localparam bit POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (sts.req_valid) begin
               state_in = POW2 ? ST_EXEC : ST_DIV;
            end
         end
         ST_DIV: begin
            if (sts.div_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            if (!sts.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.load   = sts.req_valid;
            cmd.rd_req = sts.req_valid && POW2;
         end
         ST_DIV:  cmd.div_step = 1'b1;
         ST_READ: cmd.rd_rem   = 1'b1;
         ST_EXEC: cmd.exec     = !sts.out_busy;
         default: cmd = '0;
      endcase
   end

endmodule

// ===== hdl/hkoi_dpath.sv =====
// datapath: request registers, bucket remainder unit, bucket row memory,
// valid flops, way compare and result register; depends on hkoi_pkg

module hkoi_dpath import hkoi_pkg::*; #(
   parameter int BUCKETS = DEF_BUCKETS,
   parameter int WAYS    = DEF_WAYS
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic              req_valid,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [HASH_W-1:0] req_key_digest,
   input  logic [OFF_W-1:0]  req_offset,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_found,
   output logic [OFF_W-1:0]  rsp_offset_out,
   output logic              rsp_status
);

   localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW_W = WAYS * ENTRY_W;

   // request registers
   mode_type          mode_ff;
   logic [HASH_W-1:0] hash_ff;
   logic [OFF_W-1:0]  off_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= mode_type'(req_mode);
         hash_ff <= req_key_digest;
         off_ff  <= req_offset;
      end
   end

   // remainder unit: hash mod BUCKETS, one byte per step
   logic [BW-1:0]     rem_ff, rem_in;
   logic [HASH_W-1:0] sr_ff;
   logic [CNT_W-1:0]  cnt_ff;

   always_comb begin
      logic [BW:0] t;
      rem_in = rem_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         t = {rem_in, sr_ff[HASH_W-1-i]};
         if (t >= (BW+1)'(BUCKETS)) begin
            t = t - (BW+1)'(BUCKETS);
         end
         rem_in = t[BW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff <= '0;
         sr_ff  <= req_key_digest;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         sr_ff  <= sr_ff << DIV_BITS;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // bucket row memory, one row per bucket, read registered
   logic [ROW_W-1:0] mem [BUCKETS];
   logic [ROW_W-1:0] rd_data_ff;
   logic [ROW_W-1:0] wr_row;
   logic             mem_we;
   logic [BW-1:0]    req_bucket;
   logic [BW-1:0]    rd_addr;
   logic [BW-1:0]    bucket_ff;
   logic             rd_en;

   assign req_bucket = BW'(req_key_digest & HASH_W'(BUCKETS - 1));
   assign rd_addr    = cmd.rd_req ? req_bucket : rem_ff;
   assign rd_en      = cmd.rd_req | cmd.rd_rem;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         bucket_ff  <= rd_addr;
      end
      if (mem_we) begin
         mem[bucket_ff] <= wr_row;
      end
   end

   // way compare and update decision
   logic [BUCKETS-1:0][WAYS-1:0] valid_ff;
   logic [WAYS-1:0]  valid_row;
   logic             hit, free_any;
   logic [WW-1:0]    hit_way, free_way, tgt_way;
   logic [OFF_W-1:0] hit_off;
   logic             upd_write, set_valid, clr_valid, clr_all;
   logic             found_in, status_in;
   logic [OFF_W-1:0] off_out_in;

   assign valid_row = valid_ff[bucket_ff];

   always_comb begin
      hit      = 1'b0;
      free_any = 1'b0;
      hit_way  = '0;
      free_way = '0;
      hit_off  = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!hit && valid_row[w]
             && rd_data_ff[w*ENTRY_W+OFF_W +: HASH_W] == hash_ff) begin
            hit     = 1'b1;
            hit_way = WW'(w);
            hit_off = rd_data_ff[w*ENTRY_W +: OFF_W];
         end
         if (!free_any && !valid_row[w]) begin
            free_any = 1'b1;
            free_way = WW'(w);
         end
      end
   end

   always_comb begin
      upd_write  = 1'b0;
      set_valid  = 1'b0;
      clr_valid  = 1'b0;
      clr_all    = 1'b0;
      tgt_way    = hit_way;
      found_in   = hit;
      status_in  = 1'b0;
      off_out_in = '0;
      case (mode_ff)
         MODE_UPDATE: begin
            if (hit) begin
               upd_write = 1'b1;
            end else if (free_any) begin
               upd_write = 1'b1;
               set_valid = 1'b1;
               tgt_way   = free_way;
            end else begin
               status_in = 1'b1;
            end
         end
         MODE_FIND: begin
            if (hit) begin
               off_out_in = hit_off;
            end
         end
         MODE_REMOVE: clr_valid = hit;
         MODE_CLEAR: begin
            clr_all  = 1'b1;
            found_in = 1'b0;
         end
         default: found_in = 1'b0;
      endcase
   end

   always_comb begin
      wr_row = rd_data_ff;
      for (int w = 0; w < WAYS; w++) begin
         if (tgt_way == WW'(w)) begin
            wr_row[w*ENTRY_W +: ENTRY_W] = {hash_ff, off_ff};
         end
      end
   end

   assign mem_we = cmd.exec && upd_write;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.exec) begin
         if (clr_all) begin
            valid_ff <= '0;
         end else if (set_valid) begin
            valid_ff[bucket_ff][tgt_way] <= 1'b1;
         end else if (clr_valid) begin
            valid_ff[bucket_ff][tgt_way] <= 1'b0;
         end
      end
   end

   // result register
   logic             rsp_valid_ff;
   logic             found_ff, status_ff;
   logic [OFF_W-1:0] off_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         found_ff   <= found_in;
         status_ff  <= status_in;
         off_out_ff <= off_out_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = found_ff;
   assign rsp_offset_out = off_out_ff;
   assign rsp_status     = status_ff;

   assign sts.req_valid = req_valid;
   assign sts.div_last  = cnt_ff == CNT_W'(DIV_STEPS - 1);
   assign sts.out_busy  = rsp_valid_ff && !rsp_ready;

endmodule

// ===== hdl/hashed_key_offset_index.sv =====
// hashed key offset index: bucketed hash to offset lookup with update, find, remove, clear
// power-of-two BUCKETS: the item is accepted with its row read, then the row is compared and written back
// other BUCKETS: accept, byte-serial hash mod BUCKETS steps, row read, then compare and write-back
// the result is registered; the next item is accepted while a result waits
// reset clears all valid flops together, no sweep; row memory stays unwritten

module hashed_key_offset_index import hkoi_pkg::*; #(
   parameter int BUCKETS = DEF_BUCKETS,
   parameter int WAYS    = DEF_WAYS
) (
   input  logic        clock,
   input  logic        reset,
   hkoi_req_if.sink    req_ch,
   hkoi_rsp_if.source  rsp_ch
);

   // command and status between the controller and the datapath
   cmd_type cmd;
   sts_type sts;

   // controller sequences accept, remainder steps, row read and execute
   hkoi_ctrl #(
      .BUCKETS (BUCKETS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .sts       (sts),
      .cmd       (cmd),
      .req_ready (req_ch.ready)
   );

   // datapath owns the row memory, valid flops and result register
   hkoi_dpath #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_valid      (req_ch.valid),
      .req_mode       (req_ch.mode),
      .req_key_digest (req_ch.key_digest),
      .req_offset     (req_ch.offset),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_found      (rsp_ch.found),
      .rsp_offset_out (rsp_ch.offset_out),
      .rsp_status     (rsp_ch.status)
   );

   // execute must never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> !sts.out_busy)
      else $error("execute while result register busy");

   // one item at a time: an accept drops ready on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("ready held after accepting an item");

   // a full-bucket status only comes with a miss
   a_status_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.found && rsp_ch.status))
      else $error("status and found both set");

   // a nonzero offset only comes with a hit
   a_offset_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.offset_out != '0) |-> rsp_ch.found)
      else $error("offset returned without a hit");

endmodule

// ===== verif/tb_hashed_key_offset_index.sv =====
`timescale 1ns / 100ps
// testbench for hashed_key_offset_index: directed and random update/find/remove/clear items
// checked against an in-bench bucket table; depends on hkoi_pkg, hkoi_req_if, hkoi_rsp_if

module tb_hashed_key_offset_index;
   import hkoi_pkg::*;

   localparam int unsigned NUM_BUCKETS = DEF_BUCKETS;
   localparam int unsigned NUM_WAYS    = DEF_WAYS;
   localparam int unsigned NUM_ENTRIES = NUM_BUCKETS * NUM_WAYS;
   localparam int unsigned RANDOM_ITEMS = 1300;
   localparam int unsigned POOL_SIZE    = 20;
   // no item or result may sit longer than this many quiet cycles
   localparam int unsigned STALL_LIMIT  = 500;
   // drain time once the last result is in
   localparam int unsigned DRAIN_CYCLES = 20;

   typedef struct packed {
      mode_type          mode;
      logic [HASH_W-1:0] key_digest;
      logic [OFF_W-1:0]  offset;
   } index_req_type;

   typedef struct packed {
      logic             found;
      logic [OFF_W-1:0] offset_out;
      logic             status;
   } index_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hkoi_req_if req_ch ();
   hkoi_rsp_if rsp_ch ();

   hashed_key_offset_index #(
      .BUCKETS (NUM_BUCKETS),
      .WAYS    (NUM_WAYS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #10 clock = ~clock;

   // shadow copy of the bucket table, entry index = bucket * ways + way
   bit                tbl_valid  [NUM_ENTRIES];
   logic [HASH_W-1:0] tbl_hash   [NUM_ENTRIES];
   logic [OFF_W-1:0]  tbl_offset [NUM_ENTRIES];

   index_req_type    pending_reqs [$];   // items still to be offered
   index_result_type awaited_lookups [$]; // predicted results, oldest first
   index_req_type    next_req;

   int unsigned req_gap;
   int unsigned rsp_hold;
   int unsigned accepted_cnt;
   int unsigned idle_cycles;
   int unsigned errors;
   logic        calm;   // stretches where neither side idles

   // apply one item to the shadow table and return the result it must produce
   function automatic index_result_type index_apply(index_req_type rq);
      int unsigned      base;
      int               hit_way;
      int               free_slot;
      index_result_type res;
      res       = '0;
      hit_way   = -1;
      free_slot = -1;
      base      = (rq.key_digest % NUM_BUCKETS) * NUM_WAYS;
      if (rq.mode == MODE_CLEAR) begin
         foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
         return res;
      end
      // scan downward so the lowest matching and lowest free way win
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (tbl_valid[base + w] && tbl_hash[base + w] == rq.key_digest) hit_way = w;
         if (!tbl_valid[base + w]) free_slot = w;
      end
      res.found = (hit_way >= 0);
      case (rq.mode)
         MODE_UPDATE: begin
            if (hit_way >= 0) begin
               tbl_offset[base + hit_way] = rq.offset;
            end else if (free_slot >= 0) begin
               tbl_valid[base + free_slot]  = 1'b1;
               tbl_hash[base + free_slot]   = rq.key_digest;
               tbl_offset[base + free_slot] = rq.offset;
            end else begin
               // bucket full, nothing stored
               res.status = 1'b1;
            end
         end
         MODE_FIND: begin
            if (hit_way >= 0) res.offset_out = tbl_offset[base + hit_way];
         end
         MODE_REMOVE: begin
            if (hit_way >= 0) tbl_valid[base + hit_way] = 1'b0;
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic queue_req(mode_type m, logic [HASH_W-1:0] h, logic [OFF_W-1:0] off);
      index_req_type rq;
      rq.mode       = m;
      rq.key_digest = h;
      rq.offset     = off;
      pending_reqs.push_back(rq);
   endtask

   // request driver: one item at a time, random gap after each accepted item outside calm stretches
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap      <= 0;
         accepted_cnt <= 0;
         calm         <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            awaited_lookups.push_back(index_apply('{mode: mode_type'(req_ch.mode),
                                                    key_digest: req_ch.key_digest,
                                                    offset: req_ch.offset}));
            accepted_cnt <= accepted_cnt + 1;
            // flip between idling and back-to-back every 128 items
            if (accepted_cnt % 128 == 127) calm <= ~calm;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (req_gap != 0) begin
               req_ch.valid <= 1'b0;
               req_gap      <= req_gap - 1;
            end else if (pending_reqs.size() != 0) begin
               next_req          = pending_reqs.pop_front();
               req_ch.mode       <= next_req.mode;
               req_ch.key_digest <= next_req.key_digest;
               req_ch.offset     <= next_req.offset;
               req_ch.valid      <= 1'b1;
               req_gap           <= calm ? 0 : $urandom_range(0, 4);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold     <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_lookups.size() == 0) begin
            $error("result with no item outstanding: found %0d offset_out %0h status %0d",
                   rsp_ch.found, rsp_ch.offset_out, rsp_ch.status);
            errors++;
         end else begin
            index_result_type exp_res;
            exp_res = awaited_lookups.pop_front();
            if (rsp_ch.found !== exp_res.found) begin
               $error("found: expected %0d, got %0d", exp_res.found, rsp_ch.found);
               errors++;
            end
            if (rsp_ch.offset_out !== exp_res.offset_out) begin
               $error("offset_out: expected %0h, got %0h", exp_res.offset_out,
                      rsp_ch.offset_out);
               errors++;
            end
            if (rsp_ch.status !== exp_res.status) begin
               $error("status: expected %0d, got %0d", exp_res.status, rsp_ch.status);
               errors++;
            end
         end
         // outside calm stretches, a random stall before the next result
         if (calm) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            int unsigned n;
            n = $urandom_range(0, 4);
            rsp_ch.ready <= (n == 0);
            rsp_hold     <= (n == 0) ? 0 : n - 1;
         end
      end else if (rsp_hold != 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold     <= rsp_hold - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("hashed_key_offset_index verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [HASH_W-1:0] key_pool [POOL_SIZE];
      logic [3:0]        hot_bucket [3];
      logic [HASH_W-1:0] h;
      int unsigned       pick;

      errors            = 0;
      req_ch.valid      = 1'b0;
      req_ch.mode       = MODE_FIND;
      req_ch.key_digest = '0;
      req_ch.offset     = '0;
      rsp_ch.ready      = 1'b0;

      // directed: misses on an empty table, fill bucket 5 then overflow it,
      // hit overwrite, remove hit and miss, reuse of a freed way, extremes,
      // and a clear followed by a miss
      queue_req(MODE_CLEAR,  32'h0000_0000, 16'h0000);
      queue_req(MODE_FIND,   32'h0000_0000, 16'hFFFF);
      queue_req(MODE_REMOVE, 32'h0000_0000, 16'h0000);
      queue_req(MODE_UPDATE, 32'h0000_0005, 16'hFFFF);
      queue_req(MODE_UPDATE, 32'h1234_5675, 16'h0000);
      queue_req(MODE_UPDATE, 32'hFFFF_FFF5, 16'hA5A5);
      queue_req(MODE_UPDATE, 32'h8000_0005, 16'h5A5A);
      queue_req(MODE_UPDATE, 32'h0000_0015, 16'h1111);
      queue_req(MODE_FIND,   32'h0000_0015, 16'h0000);
      queue_req(MODE_FIND,   32'h0000_0005, 16'h0000);
      queue_req(MODE_UPDATE, 32'h1234_5675, 16'h7777);
      queue_req(MODE_FIND,   32'h1234_5675, 16'h0000);
      queue_req(MODE_REMOVE, 32'hFFFF_FFF5, 16'h0000);
      queue_req(MODE_REMOVE, 32'hFFFF_FFF5, 16'h0000);
      queue_req(MODE_UPDATE, 32'h0000_0015, 16'h1111);
      queue_req(MODE_FIND,   32'h0000_0015, 16'h0000);
      queue_req(MODE_UPDATE, 32'hFFFF_FFFF, 16'h8001);
      queue_req(MODE_FIND,   32'hFFFF_FFFF, 16'h0000);
      queue_req(MODE_UPDATE, 32'h0000_0000, 16'h0001);
      queue_req(MODE_CLEAR,  32'hFFFF_FFFF, 16'hFFFF);
      queue_req(MODE_FIND,   32'h0000_0005, 16'h0000);
      queue_req(MODE_UPDATE, 32'h0000_0005, 16'h1234);
      queue_req(MODE_FIND,   32'h0000_0005, 16'h0000);

      // random: keys drawn mostly from a small pool crowded into three
      // buckets so that hits, removes and full buckets happen often
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 200 == 0) begin
            foreach (hot_bucket[b]) hot_bucket[b] = 4'($urandom_range(0, NUM_BUCKETS - 1));
            foreach (key_pool[k])
               key_pool[k] = {28'($urandom_range(0, 32'h0FFF_FFFF)), hot_bucket[k % 3]};
         end
         if ($urandom_range(0, 7) == 0) h = $urandom();
         else h = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         pick = $urandom_range(0, 99);
         if (pick < 45)      queue_req(MODE_UPDATE, h, OFF_W'($urandom_range(0, 16'hFFFF)));
         else if (pick < 75) queue_req(MODE_FIND,   h, OFF_W'($urandom_range(0, 16'hFFFF)));
         else if (pick < 98) queue_req(MODE_REMOVE, h, OFF_W'($urandom_range(0, 16'hFFFF)));
         else                queue_req(MODE_CLEAR,  h, OFF_W'($urandom_range(0, 16'hFFFF)));
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // wait for every item to go in and every prediction to be met
      while (pending_reqs.size() != 0 || req_ch.valid || awaited_lookups.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && awaited_lookups.size() == 0) begin
         $display("hashed_key_offset_index verification clean");
      end else begin
         $display("hashed_key_offset_index verification failed");
      end
      $finish;
   end

endmodule
